[hdl/rifp_pkg.sv]
// Shared types, codes and character helpers for the radix integer field parser.
package rifp_pkg;

  // Input item operation codes
  localparam logic [1:0] OP_DATA    = 2'd0;
  localparam logic [1:0] OP_END     = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;
  localparam logic [1:0] OP_RSVD    = 2'd3;

  // Radix mode codes
  localparam logic [1:0] RADIX_SDEC = 2'd0;
  localparam logic [1:0] RADIX_UDEC = 2'd1;
  localparam logic [1:0] RADIX_HEX  = 2'd2;
  localparam logic [1:0] RADIX_BIN  = 2'd3;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_RADIX_MODE  = 2'd0;
  localparam logic [1:0] REG_DIGIT_LIMIT = 2'd1;
  localparam logic [1:0] REG_LIMIT_ON    = 2'd2;
  localparam int         CFG_AW          = 4;

  // Character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_A_LO  = 8'h61;  // 'a'
  localparam logic [7:0] CH_Z_LO  = 8'h7a;  // 'z'
  localparam logic [7:0] CH_A_UP  = 8'h41;  // 'A'
  localparam logic [7:0] CH_Z_UP  = 8'h5a;  // 'Z'
  localparam logic [7:0] CH_MINUS = 8'h2d;  // '-'
  localparam logic [7:0] CH_PLUS  = 8'h2b;  // '+'
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] LETTER_BIAS = 8'd10;

  // Default result queue depth (power of two, at least 4)
  localparam int RIFP_OUTQ_DEPTH = 8;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] char_byte;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] field_value;
    logic               field_ok;
    logic               last_result;
  } out_item_t;

  typedef struct packed {
    logic [1:0] radix_mode;
    logic [7:0] digit_limit;
    logic       limit_on;
  } cfg_t;

  typedef struct packed {
    logic      vld;
    out_item_t item;
  } res_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] value;
  } digit_t;

  // Whitespace: tab through carriage return, and space
  function automatic logic is_space(input logic [7:0] c);
    return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
  endfunction

  // Digit value of c in the selected radix; hit is low when c is no such digit
  function automatic digit_t digit_of(input logic [7:0] c, input logic [1:0] radix);
    digit_t     res;
    logic [7:0] t;
    logic [4:0] base;
    logic       any;
    t   = '0;
    any = 1'b1;
    if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
      t = c - CH_ZERO;
    end else if ((c >= CH_A_LO) && (c <= CH_Z_LO)) begin
      t = c - CH_A_LO + LETTER_BIAS;
    end else if ((c >= CH_A_UP) && (c <= CH_Z_UP)) begin
      t = c - CH_A_UP + LETTER_BIAS;
    end else begin
      any = 1'b0;
    end
    unique case (radix)
      RADIX_HEX: base = 5'd16;
      RADIX_BIN: base = 5'd2;
      default:   base = 5'd10;
    endcase
    res.hit   = any && ({3'b000, t[5:0]} < {4'b0000, base});
    res.value = t[3:0];
    return res;
  endfunction

endpackage

[hdl/rifp_cfg.sv]
// Configuration register file behind the APB-style port.
module rifp_cfg import rifp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  // Register writes on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_RADIX_MODE:  cfg_r.radix_mode  <= pwdata[1:0];
        REG_DIGIT_LIMIT: cfg_r.digit_limit <= pwdata[7:0];
        REG_LIMIT_ON:    cfg_r.limit_on    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      REG_RADIX_MODE:  prdata = {30'd0, cfg_r.radix_mode};
      REG_DIGIT_LIMIT: prdata = {24'd0, cfg_r.digit_limit};
      REG_LIMIT_ON:    prdata = {31'd0, cfg_r.limit_on};
      default:         prdata = '0;
    endcase
  end

endmodule

[hdl/rifp_core.sv]
// Field state machine: applies one registered item and yields up to two results.
module rifp_core import rifp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     item_vld,
  input  in_item_t item,
  output res_t     res0,
  output res_t     res1
);

  typedef enum logic [1:0] {PH_IDLE, PH_SIGN, PH_DIGITS, PH_HALT} phase_t;

  phase_t      phase_r, phase_nxt;
  logic [63:0] acc_r, acc_nxt;     // signed running value, sign already applied
  logic        neg_r, neg_nxt;
  logic [7:0]  cnt_r, cnt_nxt;

  digit_t      dg;
  logic        allows_cur, allows_zero, cont_digit, sel_zero;
  logic [63:0] b_acc, b_mul, dd, addend, t_acc;
  logic        b_neg, t_done;
  logic [7:0]  b_cnt, t_cnt;

  // idle-phase byte outcome, always from a cleared field
  logic        ib_emit, ib_ok;
  logic [63:0] ib_val, ib_acc;
  phase_t      ib_phase;
  logic        ib_neg;
  logic [7:0]  ib_cnt;

  assign dg          = digit_of(item.char_byte, cfg.radix_mode);
  assign allows_cur  = !cfg.limit_on || (cnt_r < cfg.digit_limit);
  assign allows_zero = !cfg.limit_on || (cfg.digit_limit != 8'd0);
  assign cont_digit  = dg.hit && allows_cur;
  // a field ended by this byte restarts from zero for the same byte
  assign sel_zero    = (phase_r == PH_DIGITS) && !cont_digit;

  // Shared digit accumulate: value * base +/- digit
  always_comb begin
    b_acc = sel_zero ? 64'd0 : acc_r;
    b_cnt = sel_zero ? 8'd0  : cnt_r;
    b_neg = sel_zero ? 1'b0  : neg_r;
    unique case (cfg.radix_mode)
      RADIX_HEX: b_mul = b_acc << 4;
      RADIX_BIN: b_mul = b_acc << 1;
      default:   b_mul = (b_acc << 3) + (b_acc << 1);
    endcase
    dd     = {60'd0, dg.value};
    addend = b_neg ? (64'd0 - dd) : dd;
    t_acc  = b_mul + addend;
    t_cnt  = (b_cnt == 8'hff) ? b_cnt : (b_cnt + 8'd1);
    t_done = cfg.limit_on && (t_cnt >= cfg.digit_limit);
  end

  // Byte handling while skipping whitespace
  always_comb begin
    ib_emit  = 1'b0;
    ib_ok    = 1'b0;
    ib_val   = '0;
    ib_phase = PH_IDLE;
    ib_acc   = '0;
    ib_neg   = 1'b0;
    ib_cnt   = '0;
    if (is_space(item.char_byte)) begin
      ib_phase = PH_IDLE;
    end else if ((cfg.radix_mode == RADIX_SDEC) &&
                 ((item.char_byte == CH_PLUS) || (item.char_byte == CH_MINUS))) begin
      ib_phase = PH_SIGN;
      ib_neg   = (item.char_byte == CH_MINUS);
    end else if (dg.hit && allows_zero) begin
      if (t_done) begin
        ib_emit = 1'b1;
        ib_ok   = 1'b1;
        ib_val  = t_acc;
      end else begin
        ib_phase = PH_DIGITS;
        ib_acc   = t_acc;
        ib_cnt   = t_cnt;
      end
    end else begin
      ib_emit  = 1'b1;
      ib_phase = PH_HALT;
    end
  end

  // Next state and results
  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    res0      = '0;
    res1      = '0;
    if (item_vld) begin
      priority if (item.op == OP_RESTART) begin
        phase_nxt = PH_IDLE;
        acc_nxt   = '0;
        neg_nxt   = 1'b0;
        cnt_nxt   = '0;
      end else if ((item.op == OP_RSVD) || (phase_r == PH_HALT)) begin
        phase_nxt = phase_r;
      end else if (item.op == OP_END) begin
        if (phase_r == PH_SIGN) begin
          res0.vld  = 1'b1;
          phase_nxt = PH_HALT;
          acc_nxt   = '0;
          neg_nxt   = 1'b0;
          cnt_nxt   = '0;
        end else if (phase_r == PH_DIGITS) begin
          res0.vld              = 1'b1;
          res0.item.field_ok    = 1'b1;
          res0.item.field_value = acc_r;
          phase_nxt = PH_IDLE;
          acc_nxt   = '0;
          neg_nxt   = 1'b0;
          cnt_nxt   = '0;
        end
      end else begin
        unique case (phase_r)
          PH_IDLE: begin
            res0.vld              = ib_emit;
            res0.item.field_ok    = ib_ok;
            res0.item.field_value = ib_val;
            phase_nxt = ib_phase;
            acc_nxt   = ib_acc;
            neg_nxt   = ib_neg;
            cnt_nxt   = ib_cnt;
          end
          PH_SIGN, PH_DIGITS: begin
            if (cont_digit) begin
              if (t_done) begin
                res0.vld              = 1'b1;
                res0.item.field_ok    = 1'b1;
                res0.item.field_value = t_acc;
                phase_nxt = PH_IDLE;
                acc_nxt   = '0;
                neg_nxt   = 1'b0;
                cnt_nxt   = '0;
              end else begin
                phase_nxt = PH_DIGITS;
                acc_nxt   = t_acc;
                cnt_nxt   = t_cnt;
              end
            end else if (phase_r == PH_SIGN) begin
              // sign without digits fails
              res0.vld  = 1'b1;
              phase_nxt = PH_HALT;
              acc_nxt   = '0;
              neg_nxt   = 1'b0;
              cnt_nxt   = '0;
            end else begin
              // field ends; the same byte opens the next field
              res0.vld              = 1'b1;
              res0.item.field_ok    = 1'b1;
              res0.item.field_value = acc_r;
              res1.vld              = ib_emit;
              res1.item.field_ok    = ib_ok;
              res1.item.field_value = ib_val;
              phase_nxt = ib_phase;
              acc_nxt   = ib_acc;
              neg_nxt   = ib_neg;
              cnt_nxt   = ib_cnt;
            end
          end
          default: phase_nxt = phase_r;
        endcase
      end
    end
    res0.item.last_result = res0.vld && !res1.vld;
    res1.item.last_result = res1.vld;
  end

  // Field state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

[hdl/rifp_outq.sv]
// Result queue: takes up to two items per cycle, hands out one per cycle while out_stall is low.
module rifp_outq import rifp_pkg::*; #(
  parameter int DEPTH = RIFP_OUTQ_DEPTH,
  localparam int PW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  res_t          push0,
  input  res_t          push1,
  output logic          out_valid,
  input  logic          out_stall,
  output out_item_t     out_data,
  output logic [CW-1:0] used
);

  out_item_t     mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt, wr_ptr_2nd;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pop;

  assign out_valid  = (cnt_r != '0);
  assign out_data   = mem_r[rd_ptr_r];
  assign used       = cnt_r;
  assign pop        = out_valid && !out_stall;
  assign wr_ptr_2nd = wr_ptr_r + PW'(1);

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(push0.vld) + PW'(push1.vld);
    rd_ptr_nxt = rd_ptr_r + PW'(pop);
    cnt_nxt    = cnt_r + CW'(push0.vld) + CW'(push1.vld) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage, second item lands after the first
  always_ff @(posedge clk) begin
    if (push0.vld) begin
      mem_r[wr_ptr_r] <= push0.item;
    end
    if (push1.vld) begin
      mem_r[wr_ptr_2nd] <= push1.item;
    end
  end

endmodule

[hdl/radix_integer_field_parser.sv]
// Top level of the radix integer field parser: input register, field logic, result queue.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+-----------------------------
//   in_      | in        | in_valid / in_stall   | in_item_t  (op, char_byte)
//   out_     | out       | out_valid / out_stall | out_item_t (value, ok, last)
//   config   | in        | psel/penable, pready  | paddr, pwdata, prdata
//
// An accepted item is registered, applied to the field state in the next cycle and
// its results (zero, one or two) enter the result queue, which shows them on out_.
// One item is taken per cycle as long as the queue, after the results of the item
// already registered, has room for two more; the queue hands out one result per
// cycle while out_stall is low, so a stream that makes two results per byte fills
// the queue and is held off by in_stall. Reset is synchronous and clears field
// state, registers and the queue.
// out_stall only fills the queue; in_stall rises once it cannot take two more besides the registered item's.
module radix_integer_field_parser import rifp_pkg::*; #(
  parameter int OUTQ_DEPTH = RIFP_OUTQ_DEPTH,
  localparam int CW = $clog2(OUTQ_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int NW = CW + 1;

  cfg_t          cfg;
  logic          in_vld_r;
  in_item_t      in_item_r;
  logic          in_acc;
  res_t          res0, res1;
  logic [CW-1:0] q_used;
  logic [NW-1:0] q_need;

  rifp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Hold off when the queue could not absorb two results from the next item
  assign q_need   = {1'b0, q_used} + (in_vld_r ? NW'(2) : NW'(0));
  assign in_stall = (q_need > NW'(OUTQ_DEPTH - 2));
  assign in_acc   = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_item_r <= in_data;
    end
  end

  rifp_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .item_vld (in_vld_r),
    .item     (in_item_r),
    .res0     (res0),
    .res1     (res1)
  );

  rifp_outq #(
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push0     (res0),
    .push1     (res1),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .used      (q_used)
  );

  // A second result only follows a successful field in the first slot
  a_second_after_ok: assert property (@(posedge clk) disable iff (!rst_n)
    res1.vld |-> (res0.vld && res0.item.field_ok))
    else $error("second result without a good first result");

  // Space for two results is always reserved for a registered item
  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r |-> (q_used <= CW'(OUTQ_DEPTH - 2)))
    else $error("result queue lacks room for a registered item");

  // The input register only holds items that were accepted
  a_reg_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r |-> $past(in_valid && !in_stall))
    else $error("input register valid without an accepted item");

endmodule
